/* rtl/ocor_pkg.sv */
package ocor_pkg;

    localparam int POINT_FRAC_BITS = 20;
    localparam int WF              = 20;
    localparam int EF              = 17;
    localparam int LIN_SH          = POINT_FRAC_BITS + EF - WF;
    localparam int OUT_SH          = 2 * WF - POINT_FRAC_BITS;
    localparam int SQ_SH           = 21;

    localparam int PT_W   = 32;
    localparam int EW     = 20;
    localparam int CFG_W  = 3 * EW;
    localparam int CFG_IDX_W = 2;
    localparam int LIN_W  = 54;
    localparam int SQ_W   = 44;
    localparam int CP_W   = 65 - POINT_FRAC_BITS;
    localparam int AV_W   = 65 - WF;
    localparam int OP_W   = 65 - OUT_SH;

    localparam logic [CFG_IDX_W-1:0] REG_E_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_E_ROW2 = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_status;

    // stage map
    localparam int ISQ_STEPS = 32;
    localparam int DV1_STEPS = PT_W + WF;
    localparam int DV2_STEPS = 64;
    localparam int S_LIN  = 0;
    localparam int S_NRM  = 1;
    localparam int S_VSQ  = 2;
    localparam int S_BC   = 3;
    localparam int S_AV   = 4;
    localparam int S_A    = 5;
    localparam int S_MUL  = 6;
    localparam int S_DISC = 7;
    localparam int S_ISQ  = 8;
    localparam int S_DEN  = S_ISQ + ISQ_STEPS;
    localparam int S_DV1  = S_DEN + 1;
    localparam int S_LAM  = S_DV1 + DV1_STEPS;
    localparam int S_DP   = S_LAM + 1;
    localparam int S_MS   = S_DP + 1;
    localparam int S_M    = S_MS + 1;
    localparam int S_QT   = S_M + 1;
    localparam int S_Q    = S_QT + 1;
    localparam int S_DV2  = S_Q + 1;
    localparam int S_LAM2 = S_DV2 + DV2_STEPS;
    localparam int S_OP   = S_LAM2 + 1;
    localparam int S_OUT  = S_OP + 1;
    localparam int NSTG   = S_OUT + 1;

    typedef struct packed {
        logic signed [PT_W-1:0]  px1, py1, px2, py2;
        t_status                 st;
        logic signed [LIN_W-1:0] l0, l1, l2, l3, l4;
        logic signed [31:0]      n10, n11, n20, n21, m3;
        logic signed [LIN_W-1:0] vs0, vs1;
        logic signed [SQ_W-1:0]  sq0, sq1, sq2, sq3;
        logic signed [CP_W-1:0]  cp0, cp1;
        logic signed [31:0]      v0, v1;
        logic [30:0]             b;
        logic signed [31:0]      c;
        logic signed [AV_W-1:0]  av0, av1;
        logic signed [31:0]      a;
        logic [61:0]             bb;
        logic signed [63:0]      ac;
        logic [63:0]             rad;
        logic [31:0]             root;
        logic [33:0]             srem;
        logic [63:0]             num;
        logic [63:0]             quo;
        logic [SQ_W-1:0]         drem;
        logic [SQ_W-1:0]         dvs;
        logic                    nneg;
        logic signed [31:0]      lam;
        logic signed [31:0]      d10, d11, d20, d21;
        logic signed [LIN_W-1:0] ms10, ms11, ms20, ms21;
        logic signed [31:0]      m10, m11, m20, m21;
        logic signed [OP_W-1:0]  op0, op1, op2, op3;
    } t_item;

    typedef struct packed {
        logic signed [PT_W-1:0] x1, y1, x2, y2;
        t_status                st;
    } t_rsp;

    // round to nearest, ties up
    function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                               input int unsigned s);
        logic signed [65:0] h;
        h = 66'sd1 <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [65:0] mul_rnd(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input int unsigned s);
        logic signed [63:0] p;
        p = x * y;
        return rnd(66'(p), s);
    endfunction

    function automatic logic signed [SQ_W-1:0] sq_rnd(input logic signed [31:0] x);
        logic signed [65:0] r;
        r = mul_rnd(x, x, SQ_SH);
        return SQ_W'(r);
    endfunction

    function automatic logic signed [LIN_W-1:0] lin_sum(input logic signed [EW-1:0] ea,
                                                        input logic signed [EW-1:0] eb,
                                                        input logic signed [EW-1:0] ec,
                                                        input logic signed [31:0] x,
                                                        input logic signed [31:0] y);
        logic signed [LIN_W-1:0] pa, pb, pc;
        pa = ea * x;
        pb = eb * y;
        pc = ec;
        pc = pc <<< POINT_FRAC_BITS;
        return pa + pb + pc;
    endfunction

    function automatic logic signed [LIN_W-1:0] pair_sum(input logic signed [EW-1:0] ea,
                                                         input logic signed [EW-1:0] eb,
                                                         input logic signed [31:0] u,
                                                         input logic signed [31:0] w);
        logic signed [LIN_W-1:0] pa, pb;
        pa = ea * u;
        pb = eb * w;
        return pa + pb;
    endfunction

    // one root bit
    function automatic t_item isq_step(input t_item it);
        t_item       o;
        logic [35:0] cur, trial;
        o     = it;
        cur   = {it.srem, it.rad[63:62]};
        trial = {2'b00, it.root, 2'b01};
        if (cur >= trial) begin
            o.srem = 34'(cur - trial);
            o.root = {it.root[30:0], 1'b1};
        end else begin
            o.srem = cur[33:0];
            o.root = {it.root[30:0], 1'b0};
        end
        o.rad = {it.rad[61:0], 2'b00};
        return o;
    endfunction

    // one quotient bit
    function automatic t_item div_step(input t_item it);
        t_item         o;
        logic [SQ_W:0] cur, dv;
        o   = it;
        cur = {it.drem, it.num[63]};
        dv  = {1'b0, it.dvs};
        if (cur >= dv) begin
            o.drem = SQ_W'(cur - dv);
            o.quo  = {it.quo[62:0], 1'b1};
        end else begin
            o.drem = cur[SQ_W-1:0];
            o.quo  = {it.quo[62:0], 1'b0};
        end
        o.num = {it.num[62:0], 1'b0};
        return o;
    endfunction

endpackage

/* rtl/ocor_in_if.sv */
interface ocor_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x1;
    logic signed [31:0] in_y1;
    logic signed [31:0] in_x2;
    logic signed [31:0] in_y2;

    modport source (output valid, in_x1, in_y1, in_x2, in_y2, input ready);
    modport sink (input valid, in_x1, in_y1, in_x2, in_y2, output ready);
endinterface

/* rtl/ocor_out_if.sv */
interface ocor_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x1;
    logic signed [31:0] out_y1;
    logic signed [31:0] out_x2;
    logic signed [31:0] out_y2;
    logic [1:0]         status;

    modport source (output valid, out_x1, out_y1, out_x2, out_y2, status, input ready);
    modport sink (input valid, out_x1, out_y1, out_x2, out_y2, status, output ready);
endinterface

/* rtl/optimal_correspondence_correction.sv */
// Throughput: one request per cycle while the skid entry is empty; 166 register
// stages including a 32-stage square root and two bit-per-stage dividers
// (52 and 64 stages).
// A two-entry output buffer lets the pipeline run while a result waits.
// Synchronous active-low reset clears valid bits and the E registers.
module optimal_correspondence_correction
    import ocor_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ocor_in_if.sink              i_req,
    ocor_out_if.source           o_rsp
);

    logic [CFG_W-1:0]    r_e_row [3];
    logic signed [EW-1:0] w_e [3][3];

    t_item            n_pipe [NSTG];
    t_item            r_pipe [NSTG];
    logic [NSTG-1:0]  r_vld;
    t_item            w_in;
    logic             w_en;
    logic             w_push;
    logic             w_pop;
    t_rsp             w_new;
    t_rsp             r_out;
    t_rsp             r_skid;
    logic             r_out_v;
    logic             r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_row[0] <= '0;
            r_e_row[1] <= '0;
            r_e_row[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_E_ROW0: r_e_row[0] <= i_cfg_data;
                REG_E_ROW1: r_e_row[1] <= i_cfg_data;
                REG_E_ROW2: r_e_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_e[r][c] = $signed(r_e_row[r][EW*c +: EW]);
            end
        end
    end

    always_comb begin
        w_in     = '0;
        w_in.px1 = i_req.in_x1;
        w_in.py1 = i_req.in_y1;
        w_in.px2 = i_req.in_x2;
        w_in.py2 = i_req.in_y2;
    end

    // epipolar line sums
    always_comb begin : p_lin
        t_item it;
        it    = w_in;
        it.l0 = lin_sum(w_e[0][0], w_e[0][1], w_e[0][2], it.px2, it.py2);
        it.l1 = lin_sum(w_e[1][0], w_e[1][1], w_e[1][2], it.px2, it.py2);
        it.l2 = lin_sum(w_e[0][0], w_e[1][0], w_e[2][0], it.px1, it.py1);
        it.l3 = lin_sum(w_e[0][1], w_e[1][1], w_e[2][1], it.px1, it.py1);
        it.l4 = lin_sum(w_e[2][0], w_e[2][1], w_e[2][2], it.px2, it.py2);
        n_pipe[S_LIN] = it;
    end

    always_comb begin : p_nrm
        t_item it;
        it     = r_pipe[S_NRM-1];
        it.n10 = sat32(rnd(66'(it.l0), LIN_SH));
        it.n11 = sat32(rnd(66'(it.l1), LIN_SH));
        it.n20 = sat32(rnd(66'(it.l2), LIN_SH));
        it.n21 = sat32(rnd(66'(it.l3), LIN_SH));
        it.m3  = sat32(rnd(66'(it.l4), LIN_SH));
        n_pipe[S_NRM] = it;
    end

    always_comb begin : p_vsq
        t_item              it;
        logic signed [65:0] t0, t1;
        it     = r_pipe[S_VSQ-1];
        it.vs0 = pair_sum(w_e[0][0], w_e[0][1], it.n20, it.n21);
        it.vs1 = pair_sum(w_e[1][0], w_e[1][1], it.n20, it.n21);
        it.sq0 = sq_rnd(it.n10);
        it.sq1 = sq_rnd(it.n11);
        it.sq2 = sq_rnd(it.n20);
        it.sq3 = sq_rnd(it.n21);
        t0     = mul_rnd(it.px1, it.n10, POINT_FRAC_BITS);
        t1     = mul_rnd(it.py1, it.n11, POINT_FRAC_BITS);
        it.cp0 = CP_W'(t0);
        it.cp1 = CP_W'(t1);
        n_pipe[S_VSQ] = it;
    end

    always_comb begin : p_bc
        t_item                it;
        logic signed [SQ_W+1:0] bs;
        it   = r_pipe[S_BC-1];
        it.v0 = sat32(rnd(66'(it.vs0), EF));
        it.v1 = sat32(rnd(66'(it.vs1), EF));
        bs   = (SQ_W+2)'(it.sq0) + (SQ_W+2)'(it.sq1) + (SQ_W+2)'(it.sq2)
             + (SQ_W+2)'(it.sq3);
        it.b = (|bs[SQ_W+1:31]) ? '1 : bs[30:0];
        it.c = sat32(66'(it.cp0) + 66'(it.cp1) + 66'(it.m3));
        n_pipe[S_BC] = it;
    end

    always_comb begin : p_av
        t_item              it;
        logic signed [65:0] t0, t1;
        it     = r_pipe[S_AV-1];
        t0     = mul_rnd(it.n10, it.v0, WF);
        t1     = mul_rnd(it.n11, it.v1, WF);
        it.av0 = AV_W'(t0);
        it.av1 = AV_W'(t1);
        n_pipe[S_AV] = it;
    end

    always_comb begin : p_a
        t_item it;
        it   = r_pipe[S_A-1];
        it.a = sat32(66'(it.av0) + 66'(it.av1));
        n_pipe[S_A] = it;
    end

    always_comb begin : p_mul
        t_item it;
        it    = r_pipe[S_MUL-1];
        it.bb = it.b * it.b;
        it.ac = it.a * it.c;
        n_pipe[S_MUL] = it;
    end

    always_comb begin : p_disc
        t_item              it;
        logic signed [65:0] dsc;
        it      = r_pipe[S_DISC-1];
        dsc     = $signed({4'b0000, it.bb}) - 66'(it.ac);
        it.root = '0;
        it.srem = '0;
        if (dsc[65]) begin
            it.st  = ST_NEG_DISC;
            it.rad = '0;
        end else begin
            it.rad = dsc[63:0];
        end
        n_pipe[S_DISC] = it;
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        always_comb n_pipe[S_ISQ+k] = isq_step(r_pipe[S_ISQ+k-1]);
    end

    always_comb begin : p_den
        t_item       it;
        logic [32:0] den;
        logic [31:0] cmag;
        it   = r_pipe[S_DEN-1];
        den  = 33'(it.b) + 33'(it.root);
        cmag = it.c[31] ? (32'(~it.c) + 32'd1) : 32'(it.c);
        if (it.st == ST_OK && den == '0) begin
            it.st = ST_ZERO_DEN;
        end
        it.dvs  = (den == '0) ? SQ_W'(1) : SQ_W'(den);
        it.num  = {cmag, 32'd0};
        it.nneg = it.c[31];
        it.quo  = '0;
        it.drem = '0;
        n_pipe[S_DEN] = it;
    end

    for (genvar k = 0; k < DV1_STEPS; k++) begin : g_dv1
        always_comb n_pipe[S_DV1+k] = div_step(r_pipe[S_DV1+k-1]);
    end

    always_comb begin : p_lam
        t_item              it;
        logic signed [65:0] qv;
        it = r_pipe[S_LAM-1];
        qv = $signed({2'b00, it.quo});
        if (it.nneg) begin
            qv = -qv;
        end
        it.lam = sat32(qv);
        n_pipe[S_LAM] = it;
    end

    always_comb begin : p_dp
        t_item it;
        it     = r_pipe[S_DP-1];
        it.d10 = sat32(mul_rnd(it.lam, it.n10, WF));
        it.d11 = sat32(mul_rnd(it.lam, it.n11, WF));
        it.d20 = sat32(mul_rnd(it.lam, it.n20, WF));
        it.d21 = sat32(mul_rnd(it.lam, it.n21, WF));
        n_pipe[S_DP] = it;
    end

    always_comb begin : p_ms
        t_item it;
        it      = r_pipe[S_MS-1];
        it.ms10 = pair_sum(w_e[0][0], w_e[0][1], it.d20, it.d21);
        it.ms11 = pair_sum(w_e[1][0], w_e[1][1], it.d20, it.d21);
        it.ms20 = pair_sum(w_e[0][0], w_e[1][0], it.d10, it.d11);
        it.ms21 = pair_sum(w_e[0][1], w_e[1][1], it.d10, it.d11);
        n_pipe[S_MS] = it;
    end

    always_comb begin : p_m
        t_item it;
        it     = r_pipe[S_M-1];
        it.m10 = sat32(66'(it.n10) - rnd(66'(it.ms10), EF));
        it.m11 = sat32(66'(it.n11) - rnd(66'(it.ms11), EF));
        it.m20 = sat32(66'(it.n20) - rnd(66'(it.ms20), EF));
        it.m21 = sat32(66'(it.n21) - rnd(66'(it.ms21), EF));
        n_pipe[S_M] = it;
    end

    always_comb begin : p_qt
        t_item              it;
        logic signed [64:0] tp;
        it      = r_pipe[S_QT-1];
        it.sq0  = sq_rnd(it.m10);
        it.sq1  = sq_rnd(it.m11);
        it.sq2  = sq_rnd(it.m20);
        it.sq3  = sq_rnd(it.m21);
        tp      = it.lam * $signed({1'b0, it.root});
        it.nneg = tp[64];
        it.num  = tp[64] ? 64'(-tp) : 64'(tp);
        n_pipe[S_QT] = it;
    end

    always_comb begin : p_q
        t_item                  it;
        logic signed [SQ_W+1:0] qs;
        it = r_pipe[S_Q-1];
        qs = (SQ_W+2)'(it.sq0) + (SQ_W+2)'(it.sq1) + (SQ_W+2)'(it.sq2)
           + (SQ_W+2)'(it.sq3);
        if (it.st == ST_OK && qs == '0) begin
            it.st = ST_ZERO_DEN;
        end
        it.dvs  = (qs == '0) ? SQ_W'(1) : SQ_W'(qs);
        it.quo  = '0;
        it.drem = '0;
        n_pipe[S_Q] = it;
    end

    for (genvar k = 0; k < DV2_STEPS; k++) begin : g_dv2
        always_comb n_pipe[S_DV2+k] = div_step(r_pipe[S_DV2+k-1]);
    end

    always_comb begin : p_lam2
        t_item              it;
        logic signed [65:0] qv;
        it = r_pipe[S_LAM2-1];
        qv = $signed({2'b00, it.quo});
        if (it.nneg) begin
            qv = -qv;
        end
        it.lam = sat32(qv);
        n_pipe[S_LAM2] = it;
    end

    always_comb begin : p_op
        t_item              it;
        logic signed [65:0] t0, t1, t2, t3;
        it     = r_pipe[S_OP-1];
        t0     = mul_rnd(it.lam, it.m10, OUT_SH);
        t1     = mul_rnd(it.lam, it.m11, OUT_SH);
        t2     = mul_rnd(it.lam, it.m20, OUT_SH);
        t3     = mul_rnd(it.lam, it.m21, OUT_SH);
        it.op0 = OP_W'(t0);
        it.op1 = OP_W'(t1);
        it.op2 = OP_W'(t2);
        it.op3 = OP_W'(t3);
        n_pipe[S_OP] = it;
    end

    always_comb begin : p_out
        t_item it;
        it = r_pipe[S_OUT-1];
        if (it.st == ST_OK) begin
            it.px1 = sat32(66'(it.px1) - 66'(it.op0));
            it.py1 = sat32(66'(it.py1) - 66'(it.op1));
            it.px2 = sat32(66'(it.px2) - 66'(it.op2));
            it.py2 = sat32(66'(it.py2) - 66'(it.op3));
        end
        n_pipe[S_OUT] = it;
    end

    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // output register plus skid entry
    assign w_push   = w_en && r_vld[NSTG-1];
    assign w_pop    = r_out_v && o_rsp.ready;
    assign w_new.x1 = r_pipe[NSTG-1].px1;
    assign w_new.y1 = r_pipe[NSTG-1].py1;
    assign w_new.x2 = r_pipe[NSTG-1].px2;
    assign w_new.y2 = r_pipe[NSTG-1].py2;
    assign w_new.st = r_pipe[NSTG-1].st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skid_v <= 1'b1;
            end
            r_out_v <= 1'b1;
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skid <= w_new;
            end else begin
                r_out <= w_new;
            end
        end
    end

    assign o_rsp.valid  = r_out_v;
    assign o_rsp.out_x1 = r_out.x1;
    assign o_rsp.out_y1 = r_out.y1;
    assign o_rsp.out_x2 = r_out.x2;
    assign o_rsp.out_y2 = r_out.y2;
    assign o_rsp.status = r_out.st;

endmodule

/* rtl/ocor_chk.sv */
module ocor_chk
    import ocor_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_out_x1,
    input logic signed [31:0] i_out_y1,
    input logic signed [31:0] i_out_x2,
    input logic signed [31:0] i_out_y2,
    input logic [1:0]         i_out_status
);

    localparam int CAP   = NSTG + 2;
    localparam int CNT_W = $clog2(CAP + 2);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready) begin
            n_cnt = n_cnt + 1'b1;
        end
        if (i_out_valid && i_out_ready) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_out_x1, i_out_y1, i_out_x2, i_out_y2, i_out_status}))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("back-pressure without a waiting result");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAP))
        else $error("more requests in flight than storage");

endmodule

bind optimal_correspondence_correction ocor_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_x1     (o_rsp.out_x1),
    .i_out_y1     (o_rsp.out_y1),
    .i_out_x2     (o_rsp.out_x2),
    .i_out_y2     (o_rsp.out_y2),
    .i_out_status (o_rsp.status)
);
